// ===== sv/aclr_pkg.sv =====
// shared types, constants and the command name table of the AT command line recognizer
package aclr_pkg;

  localparam int LINE_W     = 9;
  localparam int LINE_LIMIT = 322;
  localparam int NAME_MAX   = 12;
  localparam int NUM_CMDS   = 7;
  localparam int NUM_NAMES  = 9;

  // help names sit after the seven command names
  localparam int HELP_SHORT = 7;
  localparam int HELP_LONG  = 8;

  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef logic [7:0] byte_t;
  typedef logic [LINE_W-1:0] count_t;

  typedef enum logic [2:0] {
    OC_STORED   = 3'd0,
    OC_ERASED   = 3'd1,
    OC_IGNORED  = 3'd2,
    OC_OVERFLOW = 3'd3,
    OC_HELP     = 3'd4,
    OC_EMPTY    = 3'd5,
    OC_UNKNOWN  = 3'd6,
    OC_COMMAND  = 3'd7
  } outcome_e;

  typedef struct packed {
    logic       help;
    logic       hit;
    logic [2:0] index;
  } match_t;

  localparam count_t NAME_LEN [NUM_NAMES] = '{
    count_t'(2), count_t'(6), count_t'(6), count_t'(12), count_t'(11),
    count_t'(7), count_t'(6), count_t'(3), count_t'(7)
  };

  // upper case names, padded with zero bytes
  localparam byte_t NAME_TBL [NUM_NAMES][NAME_MAX] = '{
    '{"A", "T", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{"A", "T", "+", "G", "P", "S", 0, 0, 0, 0, 0, 0},
    '{"A", "T", "+", "A", "C", "C", 0, 0, 0, 0, 0, 0},
    '{"A", "T", "+", "L", "O", "R", "A", "S", "T", "A", "R", "T"},
    '{"A", "T", "+", "L", "O", "R", "A", "S", "T", "O", "P", 0},
    '{"A", "T", "+", "S", "C", "A", "N", 0, 0, 0, 0, 0},
    '{"A", "T", "+", "B", "A", "T", 0, 0, 0, 0, 0, 0},
    '{"A", "T", "?", 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{"A", "T", "+", "H", "E", "L", "P", 0, 0, 0, 0, 0}
  };

  function automatic byte_t fold_upper(byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== sv/aclr_matcher.sv =====
// case-insensitive compare of the stored line head against the help and command names
module aclr_matcher (
  input  logic [7:0]        head_i [aclr_pkg::NAME_MAX],
  input  aclr_pkg::count_t  line_len_i,
  input  aclr_pkg::count_t  cmd_len_i,
  output aclr_pkg::match_t  match_o
);
  import aclr_pkg::*;

  logic  name_eq [NUM_NAMES];
  byte_t folded  [NAME_MAX];

  always_comb begin
    for (int k = 0; k < NAME_MAX; k++) begin
      folded[k] = fold_upper(head_i[k]);
    end
    for (int n = 0; n < NUM_NAMES; n++) begin
      name_eq[n] = 1'b1;
      for (int k = 0; k < NAME_MAX; k++) begin
        if (count_t'(k) < NAME_LEN[n] && folded[k] != NAME_TBL[n][k]) begin
          name_eq[n] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    match_o       = '0;
    match_o.help  = (name_eq[HELP_SHORT] && line_len_i == NAME_LEN[HELP_SHORT]) ||
                    (name_eq[HELP_LONG] && line_len_i == NAME_LEN[HELP_LONG]);
    // lowest index wins
    for (int n = NUM_CMDS - 1; n >= 0; n--) begin
      if (name_eq[n] && cmd_len_i == NAME_LEN[n]) begin
        match_o.hit   = 1'b1;
        match_o.index = 3'(n);
      end
    end
  end

endmodule

// ===== sv/at_command_line_recognizer.sv =====
// top level of the AT command line recognizer: line editing state and result register
//
// usage
//   input channel: one received byte per transfer on ch_i (in_valid_i / in_stall_o).
//   backspace erases, CR or LF ends the line, anything else is appended. a byte
//   other than backspace arriving with the line full empties it and reports overflow.
//   output channel: one result per input byte, outcome_o and command_index_o
//   (out_valid_o / out_stall_i). command_index_o is zero unless outcome_o says command.
// registers and throughput
//   a byte is taken into an input register and its result is worked out from there
//   and loaded into the result register once that is free; the result transfer
//   follows when out_stall_i is low. one byte per cycle is sustained while out_stall_i
//   stays low, set by the single compare-and-update step between the registers.
// stalling
//   while a result waits under out_stall_i, the input register still takes one
//   more byte; in_stall_o rises only when both registers are occupied.
// reset
//   rst_ni clears the line length, the '=' and zero byte marks and both valid
//   flags. the stored line head is not cleared: only entries written during
//   the current line are ever compared.
module at_command_line_recognizer #(
  parameter int PREFIX_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] outcome_o,
  output logic [2:0] command_index_o
);
  import aclr_pkg::*;

  localparam int IDX_W = $clog2(PREFIX_DEPTH);

  // input register
  logic  s1_valid_q;
  byte_t s1_ch_q;

  // line state
  count_t count_q, count_d;
  logic   eq_seen_q, eq_seen_d;
  count_t eq_pos_q, eq_pos_d;
  logic   zero_seen_q, zero_seen_d;
  count_t zero_pos_q, zero_pos_d;
  byte_t  prefix_q [PREFIX_DEPTH];
  logic   prefix_we;

  // result register
  logic       out_valid_q;
  outcome_e   outcome_q, outcome_d;
  logic [2:0] index_q, index_d;

  logic   out_free;
  logic   fire;
  byte_t  head [NAME_MAX];
  count_t eff_len;
  count_t cmd_len;
  match_t match;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  always_comb begin
    for (int k = 0; k < NAME_MAX; k++) begin
      head[k] = prefix_q[k];
    end
  end

  // line is cut at its first zero byte, command part ends at the first '='
  assign eff_len = zero_seen_q ? zero_pos_q : count_q;
  assign cmd_len = (eq_seen_q && eq_pos_q < eff_len) ? eq_pos_q : eff_len;

  aclr_matcher u_matcher (
    .head_i     (head),
    .line_len_i (eff_len),
    .cmd_len_i  (cmd_len),
    .match_o    (match)
  );

  always_comb begin
    count_d     = count_q;
    eq_seen_d   = eq_seen_q;
    eq_pos_d    = eq_pos_q;
    zero_seen_d = zero_seen_q;
    zero_pos_d  = zero_pos_q;
    prefix_we   = 1'b0;
    outcome_d   = OC_STORED;
    index_d     = 3'd0;
    if (s1_ch_q == CH_BS) begin
      if (count_q != '0) begin
        count_d = count_q - count_t'(1);
        // erasing the first '=' or zero byte drops its mark
        if (eq_seen_q && eq_pos_q == count_d) begin
          eq_seen_d = 1'b0;
        end
        if (zero_seen_q && zero_pos_q == count_d) begin
          zero_seen_d = 1'b0;
        end
        outcome_d = OC_ERASED;
      end else begin
        outcome_d = OC_IGNORED;
      end
    end else if (count_q >= count_t'(LINE_LIMIT)) begin
      count_d     = '0;
      eq_seen_d   = 1'b0;
      eq_pos_d    = '0;
      zero_seen_d = 1'b0;
      zero_pos_d  = '0;
      outcome_d   = OC_OVERFLOW;
    end else if (s1_ch_q == CH_LF || s1_ch_q == CH_CR) begin
      if (match.help) begin
        outcome_d = OC_HELP;
      end else if (cmd_len == '0) begin
        outcome_d = OC_EMPTY;
      end else if (match.hit) begin
        outcome_d = OC_COMMAND;
        index_d   = match.index;
      end else begin
        outcome_d = OC_UNKNOWN;
      end
      count_d     = '0;
      eq_seen_d   = 1'b0;
      eq_pos_d    = '0;
      zero_seen_d = 1'b0;
      zero_pos_d  = '0;
    end else begin
      // characters beyond the stored head are counted only
      prefix_we = (count_q < count_t'(PREFIX_DEPTH));
      if (s1_ch_q == CH_EQUALS && !eq_seen_q) begin
        eq_seen_d = 1'b1;
        eq_pos_d  = count_q;
      end
      if (s1_ch_q == CH_NUL && !zero_seen_q) begin
        zero_seen_d = 1'b1;
        zero_pos_d  = count_q;
      end
      count_d = count_q + count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      eq_seen_q   <= 1'b0;
      eq_pos_q    <= '0;
      zero_seen_q <= 1'b0;
      zero_pos_q  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
        eq_seen_q   <= eq_seen_d;
        eq_pos_q    <= eq_pos_d;
        zero_seen_q <= zero_seen_d;
        zero_pos_q  <= zero_pos_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_ch_q <= ch_i;
    end
    if (fire) begin
      outcome_q <= outcome_d;
      index_q   <= index_d;
    end
    if (fire && prefix_we) begin
      prefix_q[count_q[IDX_W-1:0]] <= s1_ch_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign outcome_o       = outcome_q;
  assign command_index_o = index_q;

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the AT command line recognizer: line editing, help, commands
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import aclr_pkg::*;

  // the stored line head in the block is this deep
  localparam int HEAD_DEPTH = 16;
  // a long receiver hold-off, long enough to fill both block registers
  localparam int LONG_HOLD = 160;
  // cycles with no transfer on either side before the run is given up
  localparam int WATCHDOG_LIMIT = 1000;

  // one expected result: what the block should say about one byte
  typedef struct packed {
    outcome_e   outcome;
    logic [2:0] index;
  } result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] ch_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] outcome_o;
  logic [2:0] command_index_o;

  at_command_line_recognizer #(
    .PREFIX_DEPTH(HEAD_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ch_i           (ch_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .outcome_o      (outcome_o),
    .command_index_o(command_index_o)
  );

  // clock: 12 ns period
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // line editor mirror: our own copy of the line state
  // ---------------------------------------------------------------------------
  int    line_len;
  byte_t line_head [HEAD_DEPTH];
  bit    eq_seen;
  int    eq_pos;
  bit    nul_seen;
  int    nul_pos;

  // the seven command names in index order
  string cmd_names [NUM_CMDS] = '{
    "AT", "AT+GPS", "AT+ACC", "AT+LORASTART", "AT+LORASTOP", "AT+SCAN", "AT+BAT"
  };

  result_t expected_q [$];

  int  error_count     = 0;
  int  bytes_sent      = 0;
  int  results_checked = 0;
  int  outcome_tally [8];
  bit  send_idle_on    = 1'b1;
  bit  recv_idle_on    = 1'b1;
  bit  hold_request    = 1'b0;
  int  hold_left       = 0;
  int  quiet_cycles    = 0;

  // ascii letters only; bytes of 128 and above have no case
  function automatic byte_t upper_of(input byte_t c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c & 8'hDF;
    end
    return c;
  endfunction

  // does the stored head of length len spell name, ignoring case
  function automatic bit head_is(input int len, input string name);
    if (len != name.len() || len > HEAD_DEPTH) begin
      return 1'b0;
    end
    for (int k = 0; k < len; k++) begin
      if (upper_of(line_head[k]) != byte_t'(name[k])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void start_new_line();
    line_len = 0;
    eq_seen  = 1'b0;
    eq_pos   = 0;
    nul_seen = 1'b0;
    nul_pos  = 0;
  endfunction

  // apply one received byte to the mirrored line and say what the block reports
  function automatic result_t edit_line(input byte_t ch);
    result_t r;
    int      eff_len;
    int      cmd_len;
    bit      found;
    r.outcome = OC_STORED;
    r.index   = 3'd0;
    found     = 1'b0;
    if (ch == CH_BS) begin
      if (line_len > 0) begin
        line_len--;
        // erasing the first '=' or zero byte forgets it
        if (eq_seen && eq_pos == line_len) eq_seen = 1'b0;
        if (nul_seen && nul_pos == line_len) nul_seen = 1'b0;
        r.outcome = OC_ERASED;
      end else begin
        r.outcome = OC_IGNORED;
      end
    end else if (line_len >= LINE_LIMIT) begin
      // full line: even CR or LF throws it away
      start_new_line();
      r.outcome = OC_OVERFLOW;
    end else if (ch == CH_CR || ch == CH_LF) begin
      eff_len = nul_seen ? nul_pos : line_len;
      cmd_len = (eq_seen && eq_pos < eff_len) ? eq_pos : eff_len;
      if (head_is(eff_len, "AT?") || head_is(eff_len, "AT+HELP")) begin
        r.outcome = OC_HELP;
      end else if (cmd_len == 0) begin
        r.outcome = OC_EMPTY;
      end else begin
        r.outcome = OC_UNKNOWN;
        for (int k = 0; k < NUM_CMDS; k++) begin
          if (!found && head_is(cmd_len, cmd_names[k])) begin
            found     = 1'b1;
            r.outcome = OC_COMMAND;
            r.index   = 3'(k);
          end
        end
      end
      start_new_line();
    end else begin
      // characters past the head are counted, not kept
      if (line_len < HEAD_DEPTH) line_head[line_len] = ch;
      if (ch == CH_EQUALS && !eq_seen) begin
        eq_seen = 1'b1;
        eq_pos  = line_len;
      end
      if (ch == CH_NUL && !nul_seen) begin
        nul_seen = 1'b1;
        nul_pos  = line_len;
      end
      line_len++;
    end
    return r;
  endfunction

  // a random byte that neither edits nor ends the line
  function automatic byte_t plain_byte();
    byte_t c;
    c = byte_t'($urandom_range(255));
    if (c == CH_BS || c == CH_CR || c == CH_LF) c = c ^ 8'h40;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one byte per call, changed at the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_byte(input byte_t ch);
    @(negedge clk_i);
    if (send_idle_on && $urandom_range(99) < 13) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    ch_i       = ch;
    // hold the byte until the block takes it
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(edit_line(ch));
    bytes_sent++;
  endtask

  // sender goes quiet until every outstanding result is back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // a mostly well formed line: a name in mixed case, typos, arguments, terminator
  task automatic send_random_line();
    byte_t q [$];
    string name;
    int    pick;
    byte_t c;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // pure noise, may hold backspaces and line ends of its own
      repeat ($urandom_range(12, 1)) q.push_back(byte_t'($urandom_range(255)));
    end else begin
      if (pick < 75) name = cmd_names[$urandom_range(NUM_CMDS - 1)];
      else if (pick < 88) name = $urandom_range(1) ? "AT?" : "AT+HELP";
      else name = "";
      // a stray backspace on an empty line now and then
      if ($urandom_range(19) == 0) q.push_back(CH_BS);
      for (int k = 0; k < name.len(); k++) begin
        c = name[k];
        // typo corrected by backspace
        if ($urandom_range(9) == 0) begin
          q.push_back(plain_byte());
          q.push_back(CH_BS);
        end
        if (c >= 8'h41 && c <= 8'h5A && $urandom_range(1)) c = c | 8'h20;
        q.push_back(c);
      end
      // clipped name, usually unknown
      if (q.size() > 1 && $urandom_range(19) == 0) q.delete(q.size() - 1);
      if (name.len() == 0 || $urandom_range(9) == 0) begin
        repeat ($urandom_range(4, 1)) q.push_back(plain_byte());
      end
      // command part longer than the stored head
      if ($urandom_range(11) == 0) begin
        while (q.size() < HEAD_DEPTH + 4) q.push_back(byte_t'(8'h58 + $urandom_range(2)));
      end
      if ($urandom_range(2) == 0) begin
        q.push_back(CH_EQUALS);
        repeat ($urandom_range(6)) q.push_back(plain_byte());
      end
      if ($urandom_range(11) == 0) begin
        q.push_back(CH_NUL);
        repeat ($urandom_range(3)) q.push_back(plain_byte());
      end
      // leading '=' or zero byte leaves an empty command part
      if ($urandom_range(24) == 0) q.push_front($urandom_range(1) ? CH_EQUALS : CH_NUL);
    end
    q.push_back($urandom_range(1) ? CH_CR : CH_LF);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus an occasional long hold-off, counted here
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = recv_idle_on && ($urandom_range(99) < 13);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every transfer out is compared with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_result
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing pending: outcome %0d command_index %0d",
               outcome_o, command_index_o);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (outcome_o !== want.outcome) begin
          $error("outcome mismatch: expected %0d, actual %0d", want.outcome, outcome_o);
          error_count++;
        end
        if (command_index_o !== want.index) begin
          $error("command_index mismatch: expected %0d, actual %0d",
                 want.index, command_index_o);
          error_count++;
        end
        results_checked++;
        outcome_tally[outcome_o]++;
      end
    end
  end

  // watchdog: too long without any transfer means the block is stuck
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // edge cases of the editor in one short burst
  task automatic test_directed();
    byte_t seq [$];
    seq = '{
      CH_BS,                                         // erase on empty line, ignored
      CH_CR,                                         // empty line
      "A", "T", CH_EQUALS, CH_BS, CH_NUL, CH_BS,     // erase '=' then zero byte again
      "?", CH_CR,                                    // short help
      "a", "t", 8'hFF, CH_LF,                        // high byte, no case, unknown
      CH_EQUALS, CH_CR,                              // '=' first, empty command part
      "A", "t", "+", "B", "a", "T", CH_EQUALS, "1", CH_CR  // mixed case command with argument
    };
    foreach (seq[i]) send_byte(seq[i]);
    drain();
  endtask

  // fill the line to its limit; the next non-backspace byte empties it
  task automatic test_line_overflow();
    for (int round = 0; round < 2; round++) begin
      repeat (LINE_LIMIT) send_byte(plain_byte());
      if (round == 0) begin
        // erase at the limit still works, then refill the last place
        send_byte(CH_BS);
        send_byte(plain_byte());
        // a line end at the limit is thrown away too
        send_byte($urandom_range(1) ? CH_CR : CH_LF);
      end else begin
        send_byte(plain_byte());
      end
      // line starts over cleanly afterwards
      send_byte("a");
      send_byte("T");
      send_byte(CH_CR);
    end
    drain();
  endtask

  // random lines until about n bytes have gone in
  task automatic test_random_lines(input int n);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n) send_random_line();
    drain();
  endtask

  // receiver holds off for a long time while the sender keeps offering bytes
  task automatic test_backpressure();
    int start;
    send_idle_on = 1'b0;
    hold_request = 1'b1;
    start = bytes_sent;
    while (bytes_sent - start < 40) send_random_line();
    drain();
    send_idle_on = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    ch_i        = 8'h00;
    out_stall_i = 1'b0;
    foreach (line_head[i]) line_head[i] = 8'h00;
    foreach (outcome_tally[i]) outcome_tally[i] = 0;
    start_new_line();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_line_overflow();
    test_random_lines(70);
    // a stretch with no idling on either side
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    test_random_lines(60);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    test_backpressure();
    test_random_lines(50);

    drain();
    repeat (8) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      error_count++;
    end

    $display("summary: %0d bytes sent, %0d results checked, %0d erased, %0d erase ignored",
             bytes_sent, results_checked, outcome_tally[OC_ERASED], outcome_tally[OC_IGNORED]);
    $display("summary: %0d commands, %0d help, %0d empty, %0d unknown, %0d overflows",
             outcome_tally[OC_COMMAND], outcome_tally[OC_HELP], outcome_tally[OC_EMPTY],
             outcome_tally[OC_UNKNOWN], outcome_tally[OC_OVERFLOW]);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/aclr_pkg.sv
sv/aclr_matcher.sv
sv/at_command_line_recognizer.sv
tb/sv/testbench.sv
